// ----- design/ceg_pkg.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid package
// Shared widths, codes, item and divider types, and the saturating
// fixed-point helpers used by the grid sequencer and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ceg_pkg;

	localparam int MAX_DIM    = 256;
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 24;

	localparam int IDX_BITS  = $clog2(MAX_DIM);
	localparam int ADDR_BITS = 2 * IDX_BITS;
	localparam int DIV_BITS  = VALUE_BITS + FRAC_BITS;
	localparam int CNT_BITS  = $clog2(DIV_BITS);
	localparam int ROWS_BITS = 9;
	localparam int GAIN_BITS = 31;
	localparam int CFG_BITS  = 31;
	localparam int CIDX_BITS = 3;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [VALUE_BITS-1:0] mag_t;

	localparam val_t VMAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam val_t VMIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam val_t ONE_Q = val_t'(longint'(1) << FRAC_BITS);
	localparam val_t M2_Q  = val_t'(((longint'(3) << FRAC_BITS) + 5) / 10);
	localparam val_t B_Q   = val_t'(((longint'(1) << FRAC_BITS) + 5) / 10);

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_STEP  = 2'd2;

	localparam logic [CIDX_BITS-1:0] CFG_ROWS  = 3'd0;
	localparam logic [CIDX_BITS-1:0] CFG_COLS  = 3'd1;
	localparam logic [CIDX_BITS-1:0] CFG_ALPHA = 3'd2;
	localparam logic [CIDX_BITS-1:0] CFG_DT    = 3'd3;
	localparam logic [CIDX_BITS-1:0] CFG_KK    = 3'd4;
	localparam logic [CIDX_BITS-1:0] CFG_A     = 3'd5;
	localparam logic [CIDX_BITS-1:0] CFG_EPS   = 3'd6;
	localparam logic [CIDX_BITS-1:0] CFG_M1    = 3'd7;

	localparam logic [ROWS_BITS-1:0] RST_ROWS  = 9'd200;
	localparam logic [ROWS_BITS-1:0] RST_COLS  = 9'd200;
	localparam val_t RST_ALPHA = 32'sd3355443;
	localparam val_t RST_DT    = 32'sd1677722;
	localparam val_t RST_KK    = 32'sd134217728;
	localparam val_t RST_A     = 32'sd1677722;
	localparam val_t RST_EPS   = 32'sd167772;
	localparam val_t RST_M1    = 32'sd1174405;

	typedef struct packed {
		logic [1:0]          kind;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		val_t                exc;
		val_t                rec;
	} item_t;

	typedef struct packed {
		logic start;
		val_t num;
		val_t den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic flag;
		val_t quo;
	} div_rsp_t;

	typedef struct packed {
		logic ovf;
		val_t val;
	} satv_t;

	// Saturating add or subtract; ovf marks a clipped result.
	function automatic satv_t sat_add(val_t a, val_t b, logic sub);
		logic [VALUE_BITS:0] s;
		satv_t r;
		if (sub) s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
		else s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
		if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
			r.ovf = 1'b1;
			r.val = s[VALUE_BITS] ? VMIN : VMAX;
		end else begin
			r.ovf = 1'b0;
			r.val = s[VALUE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic satv_t sat_times4(val_t a);
		satv_t r;
		if (a[VALUE_BITS-1 -: 3] == 3'b000 || a[VALUE_BITS-1 -: 3] == 3'b111) begin
			r.ovf = 1'b0;
			r.val = a <<< 2;
		end else begin
			r.ovf = 1'b1;
			r.val = a[VALUE_BITS-1] ? VMIN : VMAX;
		end
		return r;
	endfunction

	function automatic mag_t mag(val_t a);
		mag_t u;
		u = a;
		return a[VALUE_BITS-1] ? (~u + 1'b1) : u;
	endfunction

	// Round-to-nearest scaling of a magnitude product, then saturation.
	function automatic satv_t qmul_fin(logic [2*VALUE_BITS-1:0] p, logic neg);
		logic [2*VALUE_BITS:0] sum;
		logic [2*VALUE_BITS:0] rlo;
		mag_t lim;
		mag_t m;
		satv_t r;
		sum = {1'b0, p} + ((2*VALUE_BITS+1)'(1) << (FRAC_BITS - 1));
		rlo = sum >> FRAC_BITS;
		lim = neg ? mag_t'(VMIN) : mag_t'(VMAX);
		if (rlo > (2*VALUE_BITS+1)'(lim)) begin
			r.ovf = 1'b1;
			m = lim;
		end else begin
			r.ovf = 1'b0;
			m = rlo[VALUE_BITS-1:0];
		end
		r.val = neg ? val_t'(~m + 1'b1) : val_t'(m);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/ceg_front.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid front end
// Accepts requests from the input channel and holds them in a two-entry
// queue until the grid sequencer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ceg_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic [7:0]               row_index,
	input  logic [7:0]               col_index,
	input  ceg_pkg::val_t            excitation_in,
	input  ceg_pkg::val_t            recovery_in,
	input  logic                     pop,
	output logic                     q_valid,
	output ceg_pkg::item_t           q_item
);
	import ceg_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign take     = pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{kind: kind, row: row_index, col: col_index,
				exc: excitation_in, rec: recovery_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			if (push && !take) cnt_q <= cnt_q + 2'd1;
			else if (take && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ----- design/ceg_div.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid divider
// Restoring fixed-point divider, one quotient bit per cycle. The result
// saturates out of range or for a divisor of zero or less, unless num is 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ceg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ceg_pkg::div_req_t   req,
	output ceg_pkg::div_rsp_t   rsp
);
	import ceg_pkg::*;

	logic                run_q;
	logic                done_q;
	logic                flag_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0] nsh_q;
	logic [DIV_BITS-1:0] quo_q;
	mag_t                rem_q;
	mag_t                d_q;
	logic                neg_q;
	val_t                res_q;

	logic [VALUE_BITS:0]   rr;
	logic                  ge;
	logic [VALUE_BITS:0]   rdiff;
	logic [DIV_BITS-1:0]   qn;
	mag_t                  lim;
	logic                  over;
	mag_t                  qm;
	val_t                  qval;
	mag_t                  n_mag;
	logic                  bad_den;

	always_comb begin
		rr      = {rem_q, nsh_q[DIV_BITS-1]};
		ge      = (rr >= {1'b0, d_q});
		rdiff   = rr - {1'b0, d_q};
		qn      = {quo_q[DIV_BITS-2:0], ge};
		lim     = neg_q ? mag_t'(VMIN) : mag_t'(VMAX);
		over    = (qn > DIV_BITS'(lim));
		qm      = over ? lim : qn[VALUE_BITS-1:0];
		qval    = neg_q ? val_t'(~qm + 1'b1) : val_t'(qm);
		n_mag   = mag(req.num);
		bad_den = req.den[VALUE_BITS-1] || (req.den == '0);
	end

	assign rsp = '{done: done_q, flag: flag_q, quo: res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			flag_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= req.start ? bad_den : (run_q && (cnt_q == '0));
			if (req.start) begin
				if (bad_den) begin
					flag_q <= 1'b1;
					if (n_mag == '0) res_q <= '0;
					else res_q <= req.num[VALUE_BITS-1] ? VMIN : VMAX;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CNT_BITS'(DIV_BITS - 1);
					nsh_q <= {n_mag, {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
					d_q   <= mag_t'(req.den);
					neg_q <= req.num[VALUE_BITS-1];
				end
			end else if (run_q) begin
				rem_q <= ge ? rdiff[VALUE_BITS-1:0] : rr[VALUE_BITS-1:0];
				quo_q <= qn;
				nsh_q <= nsh_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					res_q  <= qval;
					flag_q <= over;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/ceg_back.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid back end
// Holds both grids and the old-row buffer, carries out write, read and
// step requests, and sweeps the grid one cell at a time through a shared
// multiplier and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ceg_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ceg_pkg::CIDX_BITS-1:0]     cfg_index,
	input  logic [ceg_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              q_valid,
	input  ceg_pkg::item_t                    q_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind_echo,
	output ceg_pkg::val_t                     excitation_out,
	output ceg_pkg::val_t                     recovery_out,
	output logic                              saturated
);
	import ceg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_RESULT, S_FETCH, S_LAP, S_MUL, S_DIV, S_WB
	} state_t;

	localparam logic [3:0] OP_DIFF  = 4'd0;
	localparam logic [3:0] OP_REACT = 4'd1;
	localparam logic [3:0] OP_THR   = 4'd2;
	localparam logic [3:0] OP_ONE   = 4'd3;
	localparam logic [3:0] OP_ER    = 4'd4;
	localparam logic [3:0] OP_DTE   = 4'd5;
	localparam logic [3:0] OP_M1R   = 4'd6;
	localparam logic [3:0] OP_DTU   = 4'd7;
	localparam logic [3:0] OP_KKE   = 4'd8;
	localparam logic [3:0] OP_VB    = 4'd9;
	localparam logic [3:0] OP_RV    = 4'd10;

	// Fetch steps: F_CEN only reads, F_LAST only captures, others do both.
	localparam logic [2:0] F_CEN   = 3'd0;
	localparam logic [2:0] F_EAST  = 3'd1;
	localparam logic [2:0] F_WEST  = 3'd2;
	localparam logic [2:0] F_ABOVE = 3'd3;
	localparam logic [2:0] F_BELOW = 3'd4;
	localparam logic [2:0] F_LAST  = 3'd5;

	localparam logic [1:0] L_EW    = 2'd0;
	localparam logic [1:0] L_C4    = 2'd1;
	localparam logic [1:0] L_BELOW = 2'd2;
	localparam logic [1:0] L_ABOVE = 2'd3;

	function automatic logic [IDX_BITS-1:0] last_index(logic [ROWS_BITS-1:0] v);
		if (int'(v) < 2) return IDX_BITS'(1);
		else if (int'(v) > MAX_DIM) return IDX_BITS'(MAX_DIM - 1);
		else return IDX_BITS'(int'(v) - 1);
	endfunction

	// Grid stores and the old-row buffer.
	val_t e_mem [MAX_DIM*MAX_DIM];
	val_t r_mem [MAX_DIM*MAX_DIM];
	val_t b_mem [2*MAX_DIM];

	logic [ADDR_BITS-1:0] s_raddr, s_waddr;
	logic                 s_we;
	val_t                 e_wdata, r_wdata;
	logic [IDX_BITS:0]    b_raddr, b_waddr;
	logic                 b_we;
	val_t                 b_wdata;
	val_t                 e_rd_q, r_rd_q, b_rd_q;
	logic                 rd_buf;

	state_t               state_q;
	logic [ROWS_BITS-1:0] rows_q, cols_q;
	val_t                 alpha_q, dt_q, kk_q, a_q, eps_q, m1_q;
	logic [IDX_BITS-1:0]  row_q, col_q;
	logic [2:0]           fi_q;
	logic [1:0]           lap_q;
	logic [3:0]           op_q;
	logic                 ph_q;
	logic                 flag_q;
	logic                 sel_buf_q;
	val_t                 cen_q, east_q, west_q, above_q, below_q;
	val_t                 rv_q, s_q, e_q, t_q, u_q, v_q;
	logic [2*VALUE_BITS-1:0] prod_q;
	logic                 neg_q;
	logic [1:0]           res_kind_q;
	val_t                 res_e_q, res_r_q;
	logic                 res_sat_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	val_t                 out_e_q, out_r_q;
	logic                 out_sat_q;

	logic [IDX_BITS-1:0]  row_last, col_last;
	val_t                 fdata;
	val_t                 mul_a, mul_b;
	logic                 op_ovf;
	logic                 post_ovf;
	satv_t                sub_ea, sub_e1, eb, eb1, nrv, nv;
	satv_t                qf, p0, p4, p5, p10, den, us;
	satv_t                l0, c4, l1, l2, l3;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign row_last = last_index(rows_q);
	assign col_last = last_index(cols_q);
	assign fdata    = sel_buf_q ? b_rd_q : e_rd_q;
	assign pop      = (state_q == S_IDLE) && q_valid;

	assign out_valid      = out_valid_q;
	assign kind_echo      = out_kind_q;
	assign excitation_out = out_e_q;
	assign recovery_out   = out_r_q;
	assign saturated      = out_sat_q;

	// Read address selection, including the mirror boundaries.
	always_comb begin
		s_raddr = {q_item.row, q_item.col};
		b_raddr = {row_q[0], col_q};
		rd_buf  = 1'b0;
		if (state_q == S_FETCH) begin
			case (fi_q)
				F_CEN: s_raddr = {row_q, col_q};
				F_EAST: begin
					if (col_q == col_last) begin
						b_raddr = {row_q[0], col_q - 1'b1};
						rd_buf  = 1'b1;
					end else begin
						s_raddr = {row_q, col_q + 1'b1};
					end
				end
				F_WEST: begin
					if (col_q == '0) begin
						s_raddr = {row_q, IDX_BITS'(1)};
					end else begin
						b_raddr = {row_q[0], col_q - 1'b1};
						rd_buf  = 1'b1;
					end
				end
				F_ABOVE: begin
					if (row_q == '0) begin
						s_raddr = {IDX_BITS'(1), col_q};
					end else begin
						b_raddr = {!row_q[0], col_q};
						rd_buf  = 1'b1;
					end
				end
				F_BELOW: begin
					if (row_q == row_last) begin
						b_raddr = {!row_q[0], col_q};
						rd_buf  = 1'b1;
					end else begin
						s_raddr = {row_q + 1'b1, col_q};
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		s_we    = ((state_q == S_IDLE) && q_valid && (q_item.kind == KIND_WRITE))
			|| (state_q == S_WB);
		s_waddr = (state_q == S_WB) ? {row_q, col_q} : {q_item.row, q_item.col};
		e_wdata = (state_q == S_WB) ? e_q : q_item.exc;
		r_wdata = (state_q == S_WB) ? rv_q : q_item.rec;
		// The old center value is kept before the cell is overwritten.
		b_we    = (state_q == S_FETCH) && (fi_q == F_EAST);
		b_waddr = {row_q[0], col_q};
		b_wdata = e_rd_q;
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			e_mem[s_waddr] <= e_wdata;
			r_mem[s_waddr] <= r_wdata;
		end
		e_rd_q <= e_mem[s_raddr];
		r_rd_q <= r_mem[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) b_mem[b_waddr] <= b_wdata;
		b_rd_q <= b_mem[b_raddr];
	end

	// Laplacian steps.
	always_comb begin
		l0 = sat_add(east_q, west_q, 1'b0);
		c4 = sat_times4(cen_q);
		l1 = sat_add(s_q, c4.val, 1'b1);
		l2 = sat_add(s_q, below_q, 1'b0);
		l3 = sat_add(s_q, above_q, 1'b0);
	end

	// Multiplier operands and the updates that follow each product.
	always_comb begin
		sub_ea = sat_add(e_q, a_q, 1'b1);
		sub_e1 = sat_add(e_q, ONE_Q, 1'b1);
		eb     = sat_add(e_q, B_Q, 1'b1);
		eb1    = sat_add(eb.val, ONE_Q, 1'b1);
		nrv    = sat_add('0, rv_q, 1'b1);
		nv     = sat_add(nrv.val, v_q, 1'b1);
		mul_a  = '0;
		mul_b  = '0;
		op_ovf = 1'b0;
		case (op_q)
			OP_DIFF:  begin mul_a = alpha_q; mul_b = s_q; end
			OP_REACT: begin mul_a = kk_q; mul_b = e_q; end
			OP_THR:   begin mul_a = t_q; mul_b = sub_ea.val; op_ovf = sub_ea.ovf; end
			OP_ONE:   begin mul_a = t_q; mul_b = sub_e1.val; op_ovf = sub_e1.ovf; end
			OP_ER:    begin mul_a = e_q; mul_b = rv_q; end
			OP_DTE:   begin mul_a = dt_q; mul_b = t_q; end
			OP_M1R:   begin mul_a = m1_q; mul_b = rv_q; end
			OP_DTU:   begin mul_a = dt_q; mul_b = u_q; end
			OP_KKE:   begin mul_a = kk_q; mul_b = e_q; end
			OP_VB: begin
				mul_a  = v_q;
				mul_b  = eb1.val;
				op_ovf = eb.ovf || eb1.ovf;
			end
			OP_RV: begin
				mul_a  = u_q;
				mul_b  = nv.val;
				op_ovf = nrv.ovf || nv.ovf;
			end
			default: ;
		endcase

		qf  = qmul_fin(prod_q, neg_q);
		p0  = sat_add(cen_q, qf.val, 1'b0);
		p4  = sat_add(t_q, qf.val, 1'b0);
		p5  = sat_add(e_q, qf.val, 1'b1);
		p10 = sat_add(rv_q, qf.val, 1'b0);
		den = sat_add(e_q, M2_Q, 1'b0);
		us  = sat_add(eps_q, div_rsp.quo, 1'b0);
		case (op_q)
			OP_DIFF: post_ovf = p0.ovf;
			OP_ER:   post_ovf = p4.ovf;
			OP_DTE:  post_ovf = p5.ovf;
			OP_M1R:  post_ovf = den.ovf;
			OP_RV:   post_ovf = p10.ovf;
			default: post_ovf = 1'b0;
		endcase

		div_req.start = (state_q == S_MUL) && ph_q && (op_q == OP_M1R);
		div_req.num   = qf.val;
		div_req.den   = den.val;
	end

	ceg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rows_q      <= RST_ROWS;
			cols_q      <= RST_COLS;
			alpha_q     <= RST_ALPHA;
			dt_q        <= RST_DT;
			kk_q        <= RST_KK;
			a_q         <= RST_A;
			eps_q       <= RST_EPS;
			m1_q        <= RST_M1;
			row_q       <= '0;
			col_q       <= '0;
			fi_q        <= F_CEN;
			lap_q       <= L_EW;
			op_q        <= OP_DIFF;
			ph_q        <= 1'b0;
			flag_q      <= 1'b0;
			sel_buf_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS:  rows_q  <= cfg_data[ROWS_BITS-1:0];
					CFG_COLS:  cols_q  <= cfg_data[ROWS_BITS-1:0];
					CFG_ALPHA: alpha_q <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
					CFG_DT:    dt_q    <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
					CFG_KK:    kk_q    <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
					CFG_A:     a_q     <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
					CFG_EPS:   eps_q   <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
					CFG_M1:    m1_q    <= val_t'({1'b0, cfg_data[GAIN_BITS-1:0]});
				endcase
			end

			// The result state reloads the output register itself.
			if (out_valid_q && !out_stall && (state_q != S_RESULT)) out_valid_q <= 1'b0;
			sel_buf_q <= rd_buf;

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						res_kind_q <= q_item.kind;
						res_e_q    <= '0;
						res_r_q    <= '0;
						res_sat_q  <= 1'b0;
						case (q_item.kind)
							KIND_READ: state_q <= S_READ;
							KIND_STEP: begin
								row_q   <= '0;
								col_q   <= '0;
								fi_q    <= F_CEN;
								flag_q  <= 1'b0;
								state_q <= S_FETCH;
							end
							default: state_q <= S_RESULT;
						endcase
					end
				end
				S_READ: begin
					res_e_q <= e_rd_q;
					res_r_q <= r_rd_q;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_kind_q;
						out_e_q     <= res_e_q;
						out_r_q     <= res_r_q;
						out_sat_q   <= res_sat_q;
						state_q     <= S_IDLE;
					end
				end
				S_FETCH: begin
					if (fi_q == F_LAST) fi_q <= F_CEN;
					else fi_q <= fi_q + 3'd1;
					case (fi_q)
						F_EAST: begin
							cen_q <= e_rd_q;
							rv_q  <= r_rd_q;
						end
						F_WEST:  east_q  <= fdata;
						F_ABOVE: west_q  <= fdata;
						F_BELOW: above_q <= fdata;
						F_LAST: begin
							below_q <= fdata;
							lap_q   <= L_EW;
							state_q <= S_LAP;
						end
						default: ;
					endcase
				end
				S_LAP: begin
					lap_q <= lap_q + 2'd1;
					case (lap_q)
						L_EW: begin
							s_q    <= l0.val;
							flag_q <= flag_q || l0.ovf;
						end
						L_C4: begin
							s_q    <= l1.val;
							flag_q <= flag_q || c4.ovf || l1.ovf;
						end
						L_BELOW: begin
							s_q    <= l2.val;
							flag_q <= flag_q || l2.ovf;
						end
						L_ABOVE: begin
							s_q     <= l3.val;
							flag_q  <= flag_q || l3.ovf;
							op_q    <= OP_DIFF;
							ph_q    <= 1'b0;
							state_q <= S_MUL;
						end
						default: ;
					endcase
				end
				S_MUL: begin
					if (!ph_q) begin
						prod_q <= (2*VALUE_BITS)'(mag(mul_a)) * (2*VALUE_BITS)'(mag(mul_b));
						neg_q  <= mul_a[VALUE_BITS-1] != mul_b[VALUE_BITS-1];
						flag_q <= flag_q || op_ovf;
						ph_q   <= 1'b1;
					end else begin
						ph_q   <= 1'b0;
						op_q   <= op_q + 4'd1;
						flag_q <= flag_q || qf.ovf || post_ovf;
						case (op_q) inside
							OP_DIFF, OP_DTE: e_q <= (op_q == OP_DIFF) ? p0.val : p5.val;
							OP_REACT, OP_THR, OP_ONE: t_q <= qf.val;
							OP_ER: t_q <= p4.val;
							OP_M1R: state_q <= S_DIV;
							OP_DTU: u_q <= qf.val;
							OP_KKE, OP_VB: v_q <= qf.val;
							OP_RV: begin
								rv_q    <= p10.val;
								state_q <= S_WB;
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						u_q     <= us.val;
						flag_q  <= flag_q || div_rsp.flag || us.ovf;
						op_q    <= OP_DTU;
						ph_q    <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_WB: begin
					fi_q <= F_CEN;
					if (col_q == col_last) begin
						col_q <= '0;
						if (row_q == row_last) begin
							res_sat_q <= flag_q;
							state_q   <= S_RESULT;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_FETCH;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/cardiac_excitation_grid_step.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid step
// Two grids of Q8.24 excitation and recovery values with cell write, cell
// read and one explicit reaction-diffusion time step per request.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_data
//   in       in         in_valid / in_stall   kind, row_index, col_index,
//                                             excitation_in, recovery_in
//   out      out        out_valid / out_stall kind_echo, excitation_out,
//                                             recovery_out, saturated
//
// A write passes from the queue through the result state, and a read through
// the read and result states. A step sweeps every cell: each cell spends six
// fetch steps on five memory reads, four Laplacian adds, eleven products on one
// shared 32 by 32 multiplier, a bit-serial divide (cut short when the
// divisor is zero or less) and one write-back step.
// Reset clears control and restores register defaults; grid contents are
// kept only from writes. A two-entry queue takes requests while the back end
// works, and a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cardiac_excitation_grid_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ceg_pkg::CIDX_BITS-1:0]  cfg_index,
	input  logic [ceg_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     row_index,
	input  logic [7:0]                     col_index,
	input  ceg_pkg::val_t                  excitation_in,
	input  ceg_pkg::val_t                  recovery_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     kind_echo,
	output ceg_pkg::val_t                  excitation_out,
	output ceg_pkg::val_t                  recovery_out,
	output logic                           saturated
);
	import ceg_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  pop;

	ceg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.row_index     (row_index),
		.col_index     (col_index),
		.excitation_in (excitation_in),
		.recovery_in   (recovery_in),
		.pop           (pop),
		.q_valid       (q_valid),
		.q_item        (q_item)
	);

	ceg_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind_echo      (kind_echo),
		.excitation_out (excitation_out),
		.recovery_out   (recovery_out),
		.saturated      (saturated)
	);

endmodule

`default_nettype wire

// ----- design/ceg_checker.sv -----
// ----------------------------------------------------------------------------
// Cardiac excitation grid checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ceg_port_props (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [1:0]                     kind_echo,
	input  ceg_pkg::val_t                  excitation_out,
	input  ceg_pkg::val_t                  recovery_out,
	input  logic                           saturated
);
	import ceg_pkg::*;

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind_echo)
			&& $stable(excitation_out) && $stable(recovery_out) && $stable(saturated))
		else $error("stalled result changed");

	// Only a step can report saturation.
	a_sat_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind_echo != KIND_STEP |-> !saturated)
		else $error("saturation reported outside a step");

	// Only a read carries cell values.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind_echo != KIND_READ |-> excitation_out == '0 && recovery_out == '0)
		else $error("non-read result carries data");

endmodule

bind cardiac_excitation_grid_step ceg_port_props u_ceg_checker (.*);

`default_nettype wire
